@@ sv/dq_pkg.sv @@
package dq_pkg;

    typedef logic        [3:0]  cmd_t;
    typedef logic signed [63:0] word_t;
    typedef logic        [3:0]  pos_t;
    typedef logic        [1:0]  status_t;
    typedef logic        [4:0]  count_t;
    typedef logic        [2:0]  cell_mode_t;

    localparam cmd_t CMD_PUSH_BACK  = 4'd0;
    localparam cmd_t CMD_PUSH_FRONT = 4'd1;
    localparam cmd_t CMD_POP_BACK   = 4'd2;
    localparam cmd_t CMD_POP_FRONT  = 4'd3;
    localparam cmd_t CMD_PEEK_FRONT = 4'd4;
    localparam cmd_t CMD_PEEK_BACK  = 4'd5;
    localparam cmd_t CMD_FIND       = 4'd6;
    localparam cmd_t CMD_READ_AT    = 4'd7;
    localparam cmd_t CMD_DELETE_AT  = 4'd8;

    localparam status_t STAT_OK   = 2'd0;
    localparam status_t STAT_MISS = 2'd1;
    localparam status_t STAT_FULL = 2'd2;

    // per-cell update modes
    localparam cell_mode_t CM_HOLD     = 3'd0;
    localparam cell_mode_t CM_SHR      = 3'd1;  // take from the cell in front
    localparam cell_mode_t CM_SHL      = 3'd2;  // take from the cell behind
    localparam cell_mode_t CM_LOAD_AT  = 3'd3;  // selected cell loads the word
    localparam cell_mode_t CM_SHL_FROM = 3'd4;  // cells at or past sel take from the cell behind

    typedef struct packed {
        cell_mode_t mode;
        word_t      load_data;
    } cell_ctl_t;

endpackage

@@ sv/bounded_deque_with_search_core.sv @@
// Deque of up to DEPTH signed 64-bit entries held in a row of cells, front in
// cell 0. Push at either end, pop front, peek front, undefined commands and any
// command refused at once (full, empty, position out of range) give their
// result in the cycle after start and leave busy low, so the next item can follow
// immediately. Pop back, peek back, find and read at rotate the whole ring of
// cells once, one entry past cell 0 per cycle: busy stays high through the
// rotation, and the result appears in the cycle busy drops. Delete at then closes
// the gap in a further state first. done marks the single cycle a result is valid;
// the receiver cannot stall the block and must take the result in that cycle.
module bounded_deque_with_search_core #(
    parameter int DEPTH = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  dq_pkg::cmd_t    command,
    input  dq_pkg::word_t   value,
    input  dq_pkg::pos_t    position,
    output logic            done,
    output dq_pkg::word_t   data_out,
    output dq_pkg::pos_t    found_index,
    output dq_pkg::status_t status,
    output dq_pkg::count_t  entry_count
);
    import dq_pkg::*;

    localparam int IDXW = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_CLOSE = 2'd2;

    localparam logic [CNTW-1:0] FULL_COUNT = CNTW'(DEPTH);
    localparam logic [IDXW-1:0] LAST_STEP  = IDXW'(DEPTH - 1);

    logic [1:0]      state_reg, state_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic [IDXW-1:0] step_reg, step_next;
    logic [IDXW-1:0] target_reg, target_next;
    logic [IDXW-1:0] hit_reg, hit_next;
    logic            found_reg, found_next;
    cmd_t            cmd_reg, cmd_next;
    word_t           val_reg, val_next;
    word_t           cap_reg, cap_next;

    logic            done_reg, done_next;
    word_t           data_out_reg, data_out_next;
    pos_t            found_index_reg, found_index_next;
    status_t         status_reg, status_next;
    count_t          entry_count_reg, entry_count_next;

    cell_ctl_t       chain_ctl;
    logic [IDXW-1:0] chain_sel;
    word_t           cell_q [DEPTH];

    logic            accept;
    logic            is_full;
    logic            is_empty;
    logic            pos_out;
    logic            last_step;
    logic            cap_hit;
    logic            match_now;
    logic            found_any;
    logic [IDXW-1:0] hit_idx;
    word_t           cap_now;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            word_t prev_w;
            word_t next_w;
            if (g == 0)
            begin : g_head
                assign prev_w = chain_ctl.load_data;
            end
            else
            begin : g_body
                assign prev_w = cell_q[g-1];
            end
            if (g == DEPTH - 1)
            begin : g_tail
                assign next_w = cell_q[0];
            end
            else
            begin : g_link
                assign next_w = cell_q[g+1];
            end
            dq_cell #(
                .IDXW  (IDXW),
                .INDEX (g)
            ) u_cell (
                .clk       (clk),
                .ctl       (chain_ctl),
                .sel       (chain_sel),
                .prev_data (prev_w),
                .next_data (next_w),
                .data      (cell_q[g])
            );
        end
    endgenerate

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start & ~busy;
    assign is_full   = (count_reg == FULL_COUNT);
    assign is_empty  = (count_reg == '0);
    assign pos_out   = ({{CNTW{1'b0}}, position} >= {4'b0000, count_reg});
    assign last_step = (step_reg == LAST_STEP);
    assign cap_hit   = (step_reg == target_reg);
    assign cap_now   = cap_hit ? cell_q[0] : cap_reg;
    // cell 0 holds entry step_reg while the ring turns
    assign match_now = (CNTW'(step_reg) < count_reg) && (cell_q[0] == val_reg) && !found_reg;
    assign found_any = found_reg | match_now;
    assign hit_idx   = match_now ? step_reg : hit_reg;

    always_comb
    begin
        state_next          = state_reg;
        count_next          = count_reg;
        step_next           = step_reg;
        target_next         = target_reg;
        hit_next            = hit_reg;
        found_next          = found_reg;
        cmd_next            = cmd_reg;
        val_next            = val_reg;
        cap_next            = cap_reg;
        done_next           = 1'b0;
        data_out_next       = data_out_reg;
        found_index_next    = found_index_reg;
        status_next         = status_reg;
        chain_ctl.mode      = CM_HOLD;
        chain_ctl.load_data = value;
        chain_sel           = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    data_out_next    = '0;
                    found_index_next = '0;
                    status_next      = STAT_OK;
                    done_next        = 1'b1;
                    cmd_next         = command;
                    val_next         = value;
                    found_next       = 1'b0;
                    step_next        = '0;
                    unique case (command)
                        CMD_PUSH_BACK:
                        begin
                            if (is_full)
                                status_next = STAT_FULL;
                            else
                            begin
                                chain_ctl.mode = CM_LOAD_AT;
                                chain_sel      = IDXW'(count_reg);
                                count_next     = count_reg + CNTW'(1);
                            end
                        end
                        CMD_PUSH_FRONT:
                        begin
                            if (is_full)
                                status_next = STAT_FULL;
                            else
                            begin
                                chain_ctl.mode = CM_SHR;
                                count_next     = count_reg + CNTW'(1);
                            end
                        end
                        CMD_POP_FRONT, CMD_PEEK_FRONT:
                        begin
                            if (is_empty)
                                status_next = STAT_MISS;
                            else
                            begin
                                data_out_next = cell_q[0];
                                if (command == CMD_POP_FRONT)
                                begin
                                    chain_ctl.mode = CM_SHL;
                                    count_next     = count_reg - CNTW'(1);
                                end
                            end
                        end
                        CMD_POP_BACK, CMD_PEEK_BACK, CMD_FIND:
                        begin
                            if (is_empty)
                                status_next = STAT_MISS;
                            else
                            begin
                                done_next   = 1'b0;
                                state_next  = S_SCAN;
                                target_next = IDXW'(count_reg - CNTW'(1));
                            end
                        end
                        CMD_READ_AT, CMD_DELETE_AT:
                        begin
                            if (pos_out)
                                status_next = STAT_MISS;
                            else
                            begin
                                done_next   = 1'b0;
                                state_next  = S_SCAN;
                                target_next = IDXW'(position);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                chain_ctl.mode = CM_SHL;
                step_next      = step_reg + IDXW'(1);
                cap_next       = cap_now;
                found_next     = found_any;
                hit_next       = hit_idx;
                if (last_step)
                begin
                    if (cmd_reg == CMD_DELETE_AT)
                        state_next = S_CLOSE;
                    else
                    begin
                        state_next       = S_IDLE;
                        done_next        = 1'b1;
                        data_out_next    = '0;
                        found_index_next = '0;
                        status_next      = STAT_OK;
                        if (cmd_reg == CMD_FIND)
                        begin
                            if (found_any)
                                found_index_next = 4'(hit_idx);
                            else
                                status_next = STAT_MISS;
                        end
                        else
                        begin
                            data_out_next = cap_now;
                            if (cmd_reg == CMD_POP_BACK)
                                count_next = count_reg - CNTW'(1);
                        end
                    end
                end
            end
            S_CLOSE:
            begin
                chain_ctl.mode   = CM_SHL_FROM;
                chain_sel        = target_reg;
                count_next       = count_reg - CNTW'(1);
                state_next       = S_IDLE;
                done_next        = 1'b1;
                data_out_next    = cap_reg;
                found_index_next = '0;
                status_next      = STAT_OK;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        entry_count_next = done_next ? 5'(count_next) : entry_count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg        <= step_next;
        target_reg      <= target_next;
        hit_reg         <= hit_next;
        cmd_reg         <= cmd_next;
        val_reg         <= val_next;
        cap_reg         <= cap_next;
        data_out_reg    <= data_out_next;
        found_index_reg <= found_index_next;
        status_reg      <= status_next;
        entry_count_reg <= entry_count_next;
    end

    assign done        = done_reg;
    assign data_out    = data_out_reg;
    assign found_index = found_index_reg;
    assign status      = status_reg;
    assign entry_count = entry_count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("entry count above depth");

    a_count_reported: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> entry_count_reg == 5'(count_reg))
        else $error("reported count differs from held count");

    a_full_refusal: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && status_reg == STAT_FULL |-> count_reg == FULL_COUNT)
        else $error("push refused while not full");

    a_scan_steps: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN && $past(state_reg) == S_SCAN
        |-> step_reg == $past(step_reg) + IDXW'(1))
        else $error("scan step skipped");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && status_reg != STAT_OK |-> data_out_reg == '0 && found_index_reg == '0)
        else $error("data on failed item");

endmodule

@@ sv/dq_cell.sv @@
module dq_cell #(
    parameter int IDXW  = 4,
    parameter int INDEX = 0
) (
    input  logic              clk,
    input  dq_pkg::cell_ctl_t ctl,
    input  logic [IDXW-1:0]   sel,
    input  dq_pkg::word_t     prev_data,
    input  dq_pkg::word_t     next_data,
    output dq_pkg::word_t     data
);
    import dq_pkg::*;

    localparam logic [IDXW-1:0] MY_INDEX = IDXW'(INDEX);

    word_t data_reg;
    word_t data_next;

    always_comb
    begin
        unique case (ctl.mode)
            CM_HOLD:     data_next = data_reg;
            CM_SHR:      data_next = prev_data;
            CM_SHL:      data_next = next_data;
            CM_LOAD_AT:  data_next = (sel == MY_INDEX) ? ctl.load_data : data_reg;
            CM_SHL_FROM: data_next = (MY_INDEX >= sel) ? next_data : data_reg;
            default:     data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule
